// File: rtl/core/level_meter_peak_hold_assert.svh
// assertion macros for the level meter, clocked on i_clk with i_rst_n as reset
`ifndef LEVEL_METER_PEAK_HOLD_ASSERT_SVH
`define LEVEL_METER_PEAK_HOLD_ASSERT_SVH

`ifndef NO_ASSERTIONS

// consequent checked in the same cycle
`define LMPH_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("level meter check failed");

// consequent checked in the next cycle
`define LMPH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("level meter check failed");

`else

`define LMPH_ASSERT_SAME(label, ante, cons)
`define LMPH_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/core/lmph_pkg.sv
`default_nettype none

package lmph_pkg;

    // field widths
    localparam int LEVEL_W    = 16;
    localparam int HEIGHT_W   = 12;
    localparam int FACTOR_W   = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((LEVEL_W + 7) / 8) * 8;
    localparam int OUT_BITS    = 2 * HEIGHT_W + 2;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // shared multiplier operand widths
    localparam int SQ_W    = 2 * HEIGHT_W;
    localparam int MUL_A_W = (LEVEL_W > SQ_W) ? LEVEL_W : SQ_W;
    localparam int MUL_B_W = (LEVEL_W > FACTOR_W) ? LEVEL_W : FACTOR_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // full scale 1.0 in level format
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << (LEVEL_W - 1);

    // operation carried in tuser
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_FACTOR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT       = 3'd4;

    // register reset values
    localparam logic [FACTOR_W-1:0] RST_FALL_FACTOR  = 16'd58982;
    localparam logic [FACTOR_W-1:0] RST_DECAY_FACTOR = 16'd62259;
    localparam logic [LEVEL_W-1:0]  RST_PEAK_STEP    = LEVEL_W'(164);
    localparam logic [LEVEL_W-1:0]  RST_FLOOR        = LEVEL_W'(33);
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT       = HEIGHT_W'(120);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FALL,
        ST_DECAY,
        ST_PEAK,
        ST_SCALE,
        ST_LOAD,
        ST_ROOT,
        ST_DONE
    } t_state;

    // level limited to full scale
    function automatic logic [LEVEL_W-1:0] cap_level(input logic [LEVEL_W-1:0] level);
        return (level > LEVEL_ONE) ? LEVEL_ONE : level;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/level_meter_peak_hold.sv
`default_nettype none

// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tuser: func, tdata: sample_level
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: fill_height, peak_row, clip, redraw
// cfg       in   i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// a sample transaction is taken while the sequencer is idle and gives no result
// a tick steps fall, decay and peak, then scale, load and root for the fill and again
// for the peak row, on one shared multiplier and one restoring square root stepping a bit per cycle
// s_axis_tready is high only while the sequencer is idle
// the result register lets the next transaction in while a result waits
// reset (synchronous, active low) loads register defaults and zeroes all levels

`include "level_meter_peak_hold_assert.svh"

module level_meter_peak_hold (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // slave stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [lmph_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [15:0] sample_level
    input  wire logic                                s_axis_tuser,  // [0] func
    // master stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [11:0] fill_height, [23:12] peak_row, [24] clip, [25] redraw
    output logic [lmph_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // configuration writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [lmph_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [lmph_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int LW = lmph_pkg::LEVEL_W;
    localparam int HW = lmph_pkg::HEIGHT_W;
    localparam int SW = lmph_pkg::SQ_W;

    lmph_pkg::t_state r_state, n_state;

    // configuration registers
    logic [lmph_pkg::FACTOR_W-1:0] r_fall;
    logic [lmph_pkg::FACTOR_W-1:0] r_decay;
    logic [LW-1:0]                 r_step;
    logic [LW-1:0]                 r_floor;
    logic [HW-1:0]                 r_height;

    // meter state
    logic [LW-1:0] r_target;
    logic [LW-1:0] r_shown;
    logic [LW-1:0] r_peak;
    logic          r_changed;

    // datapath
    logic [lmph_pkg::PROD_W-1:0]  r_prod;
    logic [SW-1:0]                r_hh;
    logic                         r_phase;
    logic [SW-1:0]                r_rem;
    logic [SW-1:0]                r_res;
    logic [SW-1:0]                r_bit;
    logic [HW-1:0]                r_fill;
    logic [HW-1:0]                r_peak_root;

    // result register
    logic                              r_out_valid;
    logic [lmph_pkg::OUT_TDATA_W-1:0]  r_out_data;

    logic                          in_accept;
    logic                          out_free;
    logic [lmph_pkg::MUL_A_W-1:0]  mul_a;
    logic [lmph_pkg::MUL_B_W-1:0]  mul_b;
    logic [LW-1:0]                 sample;
    logic [LW-1:0]                 fallen;
    logic [LW-1:0]                 decayed;
    logic                          peak_neg;
    logic [LW-1:0]                 peak_diff;
    logic [SW:0]                   root_trial;
    logic                          root_take;
    logic [SW-1:0]                 root_rem;
    logic [SW-1:0]                 root_res;
    logic [HW-1:0]                 peak_row;
    logic                          clip;
    logic                          redraw;

    assign s_axis_tready = (r_state == lmph_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign sample        = s_axis_tdata[LW-1:0];

    // product slices and peak arithmetic
    assign fallen    = r_prod[LW+lmph_pkg::FACTOR_W-1:lmph_pkg::FACTOR_W];
    assign decayed   = r_prod[LW+lmph_pkg::FACTOR_W-1:lmph_pkg::FACTOR_W];
    assign peak_neg  = r_peak < r_step;
    assign peak_diff = r_peak - r_step;

    // one restoring square root step
    assign root_trial = {1'b0, r_res} + {1'b0, r_bit};
    assign root_take  = {1'b0, r_rem} >= root_trial;
    assign root_rem   = root_take ? (r_rem - root_trial[SW-1:0]) : r_rem;
    assign root_res   = root_take ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    // result fields
    assign peak_row = r_height - r_peak_root;
    assign clip     = r_shown > lmph_pkg::LEVEL_ONE;
    assign redraw   = r_changed || (r_peak != '0);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmph_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and multiplier operand selection
    always_comb begin
        n_state = r_state;
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            lmph_pkg::ST_IDLE: begin
                if (in_accept && (s_axis_tuser == lmph_pkg::FUNC_TICK)) begin
                    n_state = lmph_pkg::ST_FALL;
                end
            end
            lmph_pkg::ST_FALL: begin
                mul_a   = lmph_pkg::MUL_A_W'(r_shown);
                mul_b   = lmph_pkg::MUL_B_W'(r_fall);
                n_state = lmph_pkg::ST_DECAY;
            end
            lmph_pkg::ST_DECAY: begin
                mul_a   = lmph_pkg::MUL_A_W'(r_target);
                mul_b   = lmph_pkg::MUL_B_W'(r_decay);
                n_state = lmph_pkg::ST_PEAK;
            end
            lmph_pkg::ST_PEAK: begin
                mul_a   = lmph_pkg::MUL_A_W'(r_height);
                mul_b   = lmph_pkg::MUL_B_W'(r_height);
                n_state = lmph_pkg::ST_SCALE;
            end
            lmph_pkg::ST_SCALE: begin
                if (r_phase) begin
                    mul_a = lmph_pkg::MUL_A_W'(r_hh);
                    mul_b = lmph_pkg::MUL_B_W'(lmph_pkg::cap_level(r_peak));
                end else begin
                    mul_a = lmph_pkg::MUL_A_W'(r_prod[SW-1:0]);
                    mul_b = lmph_pkg::MUL_B_W'(lmph_pkg::cap_level(r_shown));
                end
                n_state = lmph_pkg::ST_LOAD;
            end
            lmph_pkg::ST_LOAD: begin
                n_state = lmph_pkg::ST_ROOT;
            end
            lmph_pkg::ST_ROOT: begin
                if (r_bit[0]) begin
                    n_state = r_phase ? lmph_pkg::ST_DONE : lmph_pkg::ST_SCALE;
                end
            end
            lmph_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = lmph_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lmph_pkg::ST_IDLE;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fall   <= lmph_pkg::RST_FALL_FACTOR;
            r_decay  <= lmph_pkg::RST_DECAY_FACTOR;
            r_step   <= lmph_pkg::RST_PEAK_STEP;
            r_floor  <= lmph_pkg::RST_FLOOR;
            r_height <= lmph_pkg::RST_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lmph_pkg::CFG_FALL_FACTOR:  r_fall   <= i_cfg_data;
                lmph_pkg::CFG_DECAY_FACTOR: r_decay  <= i_cfg_data;
                lmph_pkg::CFG_PEAK_STEP:    r_step   <= LW'(i_cfg_data);
                lmph_pkg::CFG_FLOOR:        r_floor  <= LW'(i_cfg_data);
                lmph_pkg::CFG_HEIGHT:       r_height <= HW'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // meter levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= '0;
            r_shown   <= '0;
            r_peak    <= '0;
            r_changed <= 1'b0;
        end else begin
            unique case (r_state)
                lmph_pkg::ST_IDLE: begin
                    if (in_accept && (s_axis_tuser == lmph_pkg::FUNC_SAMPLE)
                        && (sample > r_target)) begin
                        r_target <= sample;
                    end
                    if (in_accept && (s_axis_tuser == lmph_pkg::FUNC_TICK)) begin
                        r_changed <= 1'b0;
                    end
                end
                // shown level falls by the factor or jumps up to the target
                lmph_pkg::ST_DECAY: begin
                    if (r_shown > r_target) begin
                        r_shown   <= (fallen < r_target) ? r_target : fallen;
                        r_changed <= 1'b1;
                    end else if (r_shown < r_target) begin
                        r_shown   <= r_target;
                        r_changed <= 1'b1;
                    end
                end
                // target decay with silence floor, peak step with pull-up
                lmph_pkg::ST_PEAK: begin
                    r_target <= (decayed < r_floor) ? '0 : decayed;
                    r_peak   <= (peak_neg || (r_shown >= peak_diff)) ? r_shown : peak_diff;
                end
                default: begin
                end
            endcase
        end
    end

    // shared multiplier and square root datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            lmph_pkg::ST_PEAK: begin
                r_phase <= 1'b0;
            end
            lmph_pkg::ST_SCALE: begin
                if (!r_phase) begin
                    r_hh <= r_prod[SW-1:0];
                end
            end
            lmph_pkg::ST_LOAD: begin
                r_rem <= r_prod[SW+LW-2:LW-1];
                r_res <= '0;
                r_bit <= SW'(1) << (SW - 2);
            end
            lmph_pkg::ST_ROOT: begin
                r_rem <= root_rem;
                r_res <= root_res;
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    if (r_phase) begin
                        r_peak_root <= root_res[HW-1:0];
                    end else begin
                        r_fill  <= root_res[HW-1:0];
                        r_phase <= 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == lmph_pkg::ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == lmph_pkg::ST_DONE) && out_free) begin
            r_out_data <= lmph_pkg::OUT_TDATA_W'({redraw, clip, peak_row, r_fill});
        end
    end

    // checks
    `LMPH_ASSERT_NEXT(a_sample_kept, in_accept && (s_axis_tuser == lmph_pkg::FUNC_SAMPLE), r_target >= $past(sample))
    `LMPH_ASSERT_NEXT(a_shown_floor, r_state == lmph_pkg::ST_DECAY, r_shown >= $past(r_target))
    `LMPH_ASSERT_SAME(a_root_bit, r_state == lmph_pkg::ST_ROOT, $onehot(r_bit))
    `LMPH_ASSERT_SAME(a_load_from_done, $rose(r_out_valid), $past(r_state) == lmph_pkg::ST_DONE)
    `LMPH_ASSERT_SAME(a_fill_bound, r_out_valid, r_out_data[HW-1:0] <= r_height)

endmodule

`default_nettype wire

// File: verif/tb_level_meter_peak_hold.sv
`timescale 1ns / 1ps

module tb_level_meter_peak_hold;

    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;

    // one meter frame as packed on m_axis_tdata, highest field first
    typedef struct packed {
        logic                          redraw;
        logic                          clip;
        logic [lmph_pkg::HEIGHT_W-1:0] peak_row;
        logic [lmph_pkg::HEIGHT_W-1:0] fill;
    } t_meter_frame;

    // ballistics predictor and store of frames still owed by the block
    class t_meter_board;
        logic [lmph_pkg::FACTOR_W-1:0] fall_mul;
        logic [lmph_pkg::FACTOR_W-1:0] decay_mul;
        logic [lmph_pkg::LEVEL_W-1:0]  peak_step;
        logic [lmph_pkg::LEVEL_W-1:0]  floor_lvl;
        logic [lmph_pkg::HEIGHT_W-1:0] rows;
        logic [lmph_pkg::LEVEL_W-1:0]  target;
        logic [lmph_pkg::LEVEL_W-1:0]  shown;
        logic [lmph_pkg::LEVEL_W-1:0]  peak;
        t_meter_frame                  frames_due[$];
        int                            errors;

        function new();
            fall_mul  = lmph_pkg::RST_FALL_FACTOR;
            decay_mul = lmph_pkg::RST_DECAY_FACTOR;
            peak_step = lmph_pkg::RST_PEAK_STEP;
            floor_lvl = lmph_pkg::RST_FLOOR;
            rows      = lmph_pkg::RST_HEIGHT;
            target    = '0;
            shown     = '0;
            peak      = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [lmph_pkg::CFG_IDX_W-1:0] idx,
                              logic [lmph_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lmph_pkg::CFG_FALL_FACTOR:  fall_mul  = data;
                lmph_pkg::CFG_DECAY_FACTOR: decay_mul = data;
                lmph_pkg::CFG_PEAK_STEP:    peak_step = data;
                lmph_pkg::CFG_FLOOR:        floor_lvl = data;
                lmph_pkg::CFG_HEIGHT:       rows      = data[lmph_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        // floor(h * sqrt(min(1, lvl))) by bitwise root search
        function logic [lmph_pkg::HEIGHT_W-1:0] bar_rows(logic [lmph_pkg::HEIGHT_W-1:0] h,
                                                          logic [lmph_pkg::LEVEL_W-1:0] lvl);
            longint unsigned capped;
            longint unsigned radicand;
            longint unsigned root;
            longint unsigned trial;
            capped = (lvl > lmph_pkg::LEVEL_ONE) ? longint'(lmph_pkg::LEVEL_ONE)
                                                 : longint'(lvl);
            radicand = (longint'(h) * longint'(h) * capped) >> (lmph_pkg::LEVEL_W - 1);
            root = 0;
            for (int b = 20; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= radicand)
                    root = trial;
            end
            if (root > h)
                root = h;
            return root[lmph_pkg::HEIGHT_W-1:0];
        endfunction

        function void take_item(logic func, logic [lmph_pkg::LEVEL_W-1:0] level);
            t_meter_frame       f;
            logic               changed;
            logic [31:0]        prod;
            longint             next_peak;
            if (func == lmph_pkg::FUNC_SAMPLE) begin
                if (level > target)
                    target = level;
                return;
            end
            // shown level: jump up, or fall by the multiplier but not past target
            changed = 1'b0;
            if (shown > target) begin
                prod = 32'(shown) * 32'(fall_mul);
                shown = prod[31:16];
                if (shown < target)
                    shown = target;
                changed = 1'b1;
            end else if (shown < target) begin
                shown = target;
                changed = 1'b1;
            end
            // target decay with silence snap
            prod = 32'(target) * 32'(decay_mul);
            target = prod[31:16];
            if (target < floor_lvl)
                target = '0;
            // peak drops by a step, pulled up to shown level
            next_peak = longint'(peak) - longint'(peak_step);
            if (longint'(shown) >= next_peak)
                next_peak = longint'(shown);
            if (next_peak < 0)
                next_peak = 0;
            peak = next_peak[lmph_pkg::LEVEL_W-1:0];
            f.fill     = bar_rows(rows, shown);
            f.peak_row = rows - bar_rows(rows, peak);
            f.clip     = (shown > lmph_pkg::LEVEL_ONE);
            f.redraw   = changed || (peak != 0);
            frames_due.push_back(f);
        endfunction

        function void note_error(string what, int unsigned want, int unsigned got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch at %0t: %s expected %0d actual %0d", $time, what, want, got);
        endfunction

        function void check_frame(t_meter_frame got);
            t_meter_frame want;
            if (frames_due.size() == 0) begin
                note_error("frame with none outstanding, fill", 0, got.fill);
                return;
            end
            want = frames_due.pop_front();
            if (got.fill != want.fill)
                note_error("fill_height", want.fill, got.fill);
            if (got.peak_row != want.peak_row)
                note_error("peak_row", want.peak_row, got.peak_row);
            if (got.clip != want.clip)
                note_error("clip", want.clip, got.clip);
            if (got.redraw != want.redraw)
                note_error("redraw", want.redraw, got.redraw);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [lmph_pkg::IN_TDATA_W-1:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [lmph_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [lmph_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [lmph_pkg::CFG_DATA_W-1:0] i_cfg_data;

    t_meter_board board;
    bit tx_idle_en;
    bit rx_idle_en;
    int rx_hold_left;
    int rx_gap_left;

    level_meter_peak_hold dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side: long hold-off first, then random stall bursts
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left--;
        end else if (rx_gap_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_gap_left--;
        end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b0;
            rx_gap_left = $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // compare every result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_frame(m_axis_tdata[lmph_pkg::OUT_BITS-1:0]);
    end

    // one input transaction, with an optional gap before it
    task automatic send_item(input logic func, input logic [lmph_pkg::LEVEL_W-1:0] level);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= lmph_pkg::IN_TDATA_W'($urandom);
            s_axis_tuser  <= 1'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= level;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        board.take_item(func, level);
        @(negedge i_clk);
    endtask

    // stop sending and let every owed frame come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.frames_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [lmph_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lmph_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        board.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [15:0] fall, input logic [15:0] decay,
                                input logic [15:0] step, input logic [15:0] floor_val,
                                input logic [15:0] height);
        write_reg(lmph_pkg::CFG_FALL_FACTOR, fall);
        write_reg(lmph_pkg::CFG_DECAY_FACTOR, decay);
        write_reg(lmph_pkg::CFG_PEAK_STEP, step);
        write_reg(lmph_pkg::CFG_FLOOR, floor_val);
        write_reg(lmph_pkg::CFG_HEIGHT, height);
        i_cfg_valid <= 1'b0;
    endtask

    // levels biased to zero, full scale edges, saturation and near silence
    function automatic logic [lmph_pkg::LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 16'(32766 + $urandom_range(0, 4));
            3: return 16'($urandom_range(0, 64));
            4: return 16'($urandom_range(32768, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_reg(input int lo, input int hi);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    // bursts of samples closed by a tick, occasional bare ticks
    task automatic run_frames(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(0, 4);
            repeat (burst) begin
                send_item(lmph_pkg::FUNC_SAMPLE, pick_level());
                sent++;
            end
            send_item(lmph_pkg::FUNC_TICK, 16'($urandom));
            sent++;
        end
    endtask

    initial begin
        board = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        rx_hold_left  = 0;
        rx_gap_left   = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // register defaults: empty meter, saturation, full scale edges
        send_item(lmph_pkg::FUNC_TICK, '0);
        send_item(lmph_pkg::FUNC_SAMPLE, '0);
        send_item(lmph_pkg::FUNC_TICK, '1);
        send_item(lmph_pkg::FUNC_SAMPLE, '1);
        send_item(lmph_pkg::FUNC_SAMPLE, 16'd1);
        send_item(lmph_pkg::FUNC_TICK, '0);
        send_item(lmph_pkg::FUNC_TICK, '0);
        send_item(lmph_pkg::FUNC_TICK, '0);
        send_item(lmph_pkg::FUNC_SAMPLE, lmph_pkg::LEVEL_ONE);
        send_item(lmph_pkg::FUNC_TICK, '0);
        send_item(lmph_pkg::FUNC_SAMPLE, lmph_pkg::LEVEL_ONE + 16'd1);
        send_item(lmph_pkg::FUNC_TICK, '0);
        send_item(lmph_pkg::FUNC_SAMPLE, 16'd1);
        send_item(lmph_pkg::FUNC_TICK, '0);
        send_item(lmph_pkg::FUNC_SAMPLE, 16'h5555);
        send_item(lmph_pkg::FUNC_SAMPLE, 16'hAAAA);
        send_item(lmph_pkg::FUNC_TICK, '0);
        drain();

        // factors at maximum still shrink, no peak step, tallest bar
        program_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd4095);
        send_item(lmph_pkg::FUNC_SAMPLE, '1);
        send_item(lmph_pkg::FUNC_TICK, '0);
        send_item(lmph_pkg::FUNC_TICK, '0);
        send_item(lmph_pkg::FUNC_SAMPLE, 16'd33);
        send_item(lmph_pkg::FUNC_TICK, '0);
        drain();

        // zero height, zero factors, largest step and floor
        program_regs(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        send_item(lmph_pkg::FUNC_SAMPLE, 16'd40000);
        send_item(lmph_pkg::FUNC_TICK, '0);
        send_item(lmph_pkg::FUNC_TICK, '0);
        drain();

        // random settings, one per phase
        for (int ph = 0; ph < 6; ph++) begin
            program_regs(pick_reg(40000, 65535), pick_reg(40000, 65535),
                         pick_reg(0, 2000), pick_reg(0, 500),
                         ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 1) * 4095)
                                                     : 16'($urandom_range(1, 4095)));
            tx_idle_en = (ph != 5) && (ph % 3 != 2);
            rx_idle_en = (ph != 5) && (ph % 3 != 2);
            if (ph == 1)
                rx_hold_left = 300;
            run_frames(80);
            // sender waits for the block to empty mid-phase
            if (ph == 2)
                drain();
            run_frames(80);
            drain();
        end

        if (board.errors == 0 && board.frames_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
